// ----- src/uer_pkg.sv -----
`timescale 1ns / 1ps
// Package for the ultrasonic echo ranger: widths, reset values, codes and
// the structs passed between the ranger modules. No dependencies.
package uer_pkg;

    // Width of the phase and echo tick counters
    localparam int COUNT_W      = 20;
    // Echo ticks per centimetre of range
    localparam int TICKS_PER_CM = 58;
    // Width of the running remainder of the echo count by TICKS_PER_CM
    localparam int REM_W        = $clog2(TICKS_PER_CM + 1);
    localparam int DIST_W       = 15;
    localparam int STATUS_W     = 2;

    localparam logic [REM_W-1:0]  REM_LAST = REM_W'(TICKS_PER_CM - 1);
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRE_LOW      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT      = 2'd2;

    localparam int PRE_LOW_W  = 8;
    localparam int TRIG_HI_W  = 8;
    localparam int TIMEOUT_W  = 20;

    // Reset values of the configuration registers
    localparam logic [PRE_LOW_W-1:0] PRE_LOW_RST = 8'd5;
    localparam logic [TRIG_HI_W-1:0] TRIG_HI_RST = 8'd10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd1000000;

    // Measurement outcome codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_ECHO   = 2'd1,
        STATUS_ECHO_LONG = 2'd2
    } status_t;

    // Configuration as seen by the measurement core
    typedef struct packed {
        logic [PRE_LOW_W-1:0] pre_low_ticks;
        logic [TRIG_HI_W-1:0] trigger_high_ticks;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance_cm;
        status_t           status;
    } res_t;

endpackage

// ----- src/uer_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file of the ultrasonic echo ranger.
// Depends on uer_pkg for indexes, widths and reset values.
module uer_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uer_pkg::TIMEOUT_W-1:0]   cfg_data,
    output uer_pkg::cfg_t                   cfg
);

    uer_pkg::cfg_t cfg_reg;

    // Writes are always taken; an index beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pre_low_ticks      <= uer_pkg::PRE_LOW_RST;
            cfg_reg.trigger_high_ticks <= uer_pkg::TRIG_HI_RST;
            cfg_reg.timeout_ticks      <= uer_pkg::TIMEOUT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                uer_pkg::CFG_PRE_LOW: begin
                    cfg_reg.pre_low_ticks <= cfg_data[uer_pkg::PRE_LOW_W-1:0];
                end
                uer_pkg::CFG_TRIGGER_HIGH: begin
                    cfg_reg.trigger_high_ticks <= cfg_data[uer_pkg::TRIG_HI_W-1:0];
                end
                uer_pkg::CFG_TIMEOUT: begin
                    cfg_reg.timeout_ticks <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/uer_core.sv -----
`timescale 1ns / 1ps
// Measurement sequencer of the ultrasonic echo ranger: phase state, tick
// counters and the running quotient. Depends on uer_pkg.
module uer_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic          start_req,
    input  logic          echo_level,
    input  uer_pkg::cfg_t cfg,
    output uer_pkg::res_t res
);

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_PRE  = 5'b00010,
        PH_HIGH = 5'b00100,
        PH_WAIT = 5'b01000,
        PH_MEAS = 5'b10000
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [uer_pkg::COUNT_W-1:0]     phase_cnt_reg, phase_cnt_next;
    logic [uer_pkg::COUNT_W-1:0]     echo_cnt_reg, echo_cnt_next;
    logic [uer_pkg::REM_W-1:0]       rem_reg, rem_next;
    logic [uer_pkg::DIST_W-1:0]      quot_reg, quot_next;
    logic [uer_pkg::DIST_W-1:0]      dist_reg, dist_next;
    uer_pkg::status_t                status_reg, status_next;
    logic [uer_pkg::COUNT_W-1:0]     limit;

    // Timeout limit; zero behaves as one.
    always_comb begin
        limit = uer_pkg::COUNT_W'(cfg.timeout_ticks);
        if (limit == '0) begin
            limit = uer_pkg::COUNT_W'(1);
        end
    end

    // One tick: phases of zero length fall through within the same tick.
    always_comb begin
        logic settled;
        logic trig;
        logic busy;
        logic done;
        settled        = 1'b0;
        trig           = 1'b0;
        busy           = 1'b0;
        done           = 1'b0;
        phase_next     = phase_reg;
        phase_cnt_next = phase_cnt_reg;
        echo_cnt_next  = echo_cnt_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        dist_next      = dist_reg;
        status_next    = status_reg;

        if (phase_next == PH_IDLE) begin
            if (start_req) begin
                phase_next     = PH_PRE;
                phase_cnt_next = '0;
                echo_cnt_next  = '0;
            end else begin
                settled = 1'b1;
            end
        end

        // Trigger held low before the pulse
        if (!settled && phase_next == PH_PRE) begin
            if (phase_cnt_next < uer_pkg::COUNT_W'(cfg.pre_low_ticks)) begin
                phase_cnt_next = phase_cnt_next + 1'b1;
                busy           = 1'b1;
                settled        = 1'b1;
            end else begin
                phase_next     = PH_HIGH;
                phase_cnt_next = '0;
            end
        end

        // Trigger pulse
        if (!settled && phase_next == PH_HIGH) begin
            if (phase_cnt_next < uer_pkg::COUNT_W'(cfg.trigger_high_ticks)) begin
                phase_cnt_next = phase_cnt_next + 1'b1;
                trig           = 1'b1;
                busy           = 1'b1;
                settled        = 1'b1;
            end else begin
                phase_next     = PH_WAIT;
                phase_cnt_next = '0;
            end
        end

        // Waiting for the echo to rise
        if (!settled && phase_next == PH_WAIT) begin
            if (echo_level) begin
                phase_next    = PH_MEAS;
                echo_cnt_next = '0;
                rem_next      = '0;
                quot_next     = '0;
            end else begin
                phase_cnt_next = phase_cnt_next + 1'b1;
                if (phase_cnt_next >= limit) begin
                    dist_next   = '0;
                    status_next = uer_pkg::STATUS_NO_ECHO;
                    phase_next  = PH_IDLE;
                    done        = 1'b1;
                end else begin
                    busy = 1'b1;
                end
                settled = 1'b1;
            end
        end

        // Timing the echo; the quotient by TICKS_PER_CM is kept as it counts.
        if (!settled && phase_next == PH_MEAS) begin
            if (echo_level) begin
                echo_cnt_next = echo_cnt_next + 1'b1;
                if (rem_next == uer_pkg::REM_LAST) begin
                    rem_next = '0;
                    if (quot_next != uer_pkg::DIST_MAX) begin
                        quot_next = quot_next + 1'b1;
                    end
                end else begin
                    rem_next = rem_next + 1'b1;
                end
                if (echo_cnt_next >= limit) begin
                    dist_next   = '0;
                    status_next = uer_pkg::STATUS_ECHO_LONG;
                    phase_next  = PH_IDLE;
                    done        = 1'b1;
                end else begin
                    busy = 1'b1;
                end
            end else begin
                dist_next   = quot_next;
                status_next = uer_pkg::STATUS_OK;
                phase_next  = PH_IDLE;
                done        = 1'b1;
            end
            settled = 1'b1;
        end

        // Any code outside the one-hot set recovers to idle.
        if (!settled) begin
            phase_next = PH_IDLE;
        end

        res.trigger_level = trig;
        res.busy_res      = busy;
        res.done_res      = done;
        res.distance_cm   = dist_next;
        res.status        = status_next;
    end

    // State advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            phase_cnt_reg <= '0;
            echo_cnt_reg  <= '0;
            rem_reg       <= '0;
            quot_reg      <= '0;
            dist_reg      <= '0;
            status_reg    <= uer_pkg::STATUS_OK;
        end else if (step) begin
            phase_reg     <= phase_next;
            phase_cnt_reg <= phase_cnt_next;
            echo_cnt_reg  <= echo_cnt_next;
            rem_reg       <= rem_next;
            quot_reg      <= quot_next;
            dist_reg      <= dist_next;
            status_reg    <= status_next;
        end
    end

endmodule

// ----- src/ultrasonic_echo_ranger_unit.sv -----
`timescale 1ns / 1ps
// Top level of the ultrasonic echo ranger: input and output beat registers
// around the sequencer. Depends on uer_pkg, uer_cfg_regs and uer_core.
//
//   Channel  Direction  Beat carries
//   s_       in         one microsecond tick: start request, echo level
//   m_       out        one result per tick: trigger, busy, done, distance, status
//   cfg_     in         register index and value, always ready
//
// Each tick beat is registered, stepped through the sequencer and lands in
// the output register, so one beat per cycle is sustained while m_ is not
// stalled; the beat passes the input and then the output register. The
// combinational step through the phase fall-through logic sets that rate.
// Reset (aresetn low at a clock edge) empties both beat registers and returns
// to idle with the default configuration. A stall on m_ holds the output
// beat; the input register then takes a beat only while it is empty.
module ultrasonic_echo_ranger_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] start_req, [1] echo_level
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // [0] trigger_level, [1] busy_res,
                                                       // [2] done_res, [17:3] distance_cm,
                                                       // [19:18] status
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uer_pkg::TIMEOUT_W-1:0]   cfg_data
);

    localparam int RES_W = $bits(uer_pkg::res_t);

    logic          in_valid_reg;
    logic          in_start_reg;
    logic          in_echo_reg;
    logic          out_valid_reg;
    uer_pkg::res_t out_res_reg;
    uer_pkg::res_t res;
    uer_pkg::cfg_t cfg;
    logic          advance;

    assign cfg_ready = 1'b1;

    uer_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uer_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .start_req  (in_start_reg),
        .echo_level (in_echo_reg),
        .cfg        (cfg),
        .res        (res)
    );

    // A registered beat moves on when the output register is free or emptying.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_start_reg <= s_tdata[0];
            in_echo_reg  <= s_tdata[1];
        end
    end

    // Output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24 - RES_W){1'b0}},
                       out_res_reg.status,
                       out_res_reg.distance_cm,
                       out_res_reg.done_res,
                       out_res_reg.busy_res,
                       out_res_reg.trigger_level};

`ifndef SYNTHESIS
    // A finishing tick is never also a busy tick.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_res_reg.done_res && out_res_reg.busy_res))
        else $error("done and busy set on the same result");

    // The trigger is only driven during a measurement.
    a_trigger_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.trigger_level |-> out_res_reg.busy_res)
        else $error("trigger high outside a measurement");

    // A failed measurement reports no distance.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.done_res &&
        (out_res_reg.status == uer_pkg::STATUS_NO_ECHO ||
         out_res_reg.status == uer_pkg::STATUS_ECHO_LONG)
        |-> out_res_reg.distance_cm == '0)
        else $error("nonzero distance after a timeout");

    // A stalled input beat is not lost.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input beat dropped while stalled");
`endif

endmodule
